// ===== hw/rtl/complex_arith_unit_macros.svh =====
// Assertion macros for the complex arithmetic unit checker.
// Expects clk and arst_n in the scope of each use.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cau_pkg.sv =====
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package cau_pkg;
	localparam int FRAC_BITS_DEF = 8;
	localparam int DW = 16;
	localparam int QW = DW + 1;
	localparam int RW = 50;
	localparam int WW = 36;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_NEG     = 4'd4,
		OP_CONJ    = 4'd5,
		OP_NEGREAL = 4'd6,
		OP_MAG     = 4'd7,
		OP_SCALE   = 4'd8,
		OP_DIVREAL = 4'd9,
		OP_RE      = 4'd10,
		OP_IM      = 4'd11
	} op_t;

	typedef struct packed {
		logic vld;
		logic [3:0] op;
		logic signed [DW-1:0] fix_re;
		logic signed [DW-1:0] fix_im;
		logic fix_ovf;
		logic dz;
		logic sq;
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
		logic [RW-1:0] rem_re;
		logic [RW-1:0] rem_im;
		logic [RW-1:0] dvs;
		logic [QW-1:0] q_re;
		logic [QW-1:0] q_im;
	} cell_t;

	function automatic logic [DW:0] sat16(input logic signed [WW-1:0] v);
		logic [DW:0] r;
		if (v > WW'(32767)) begin
			r = {1'b1, 16'sh7fff};
		end else if (v < -WW'(32768)) begin
			r = {1'b1, 16'sh8000};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction
endpackage

// ===== hw/rtl/complex_arith_unit.sv =====
// Complex arithmetic unit top level: front end, row of divider/root cells, back end.
// Depends on cau_pkg, cau_prep, cau_cell, cau_post.
//
//  channel | handshake           | word
//  in      | in_valid / in_stall | opcode, a_re, a_im, b_re, b_im
//  out     | out_valid/out_stall | r_re, r_im, overflow, div_zero
//
// One word per cycle while no held result stalls the row; two front stages, 17 bit cells, output register.
// The 17-cell quotient/root row sets the latency.
// arst_n clears all valid state; no clearing pass.
// A held result stalls the whole row; in_stall follows out_valid && out_stall.
`timescale 1ns / 1ps
module complex_arith_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [3:0] opcode,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] r_re,
	output logic signed [15:0] r_im,
	output logic overflow,
	output logic div_zero
);
	import cau_pkg::*;

	logic en;
	cell_t chain [QW+1];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(in_valid), .opcode(opcode),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .cell_o(chain[0])
	);

	for (genvar g = 0; g < QW; g++) begin : g_cell
		cau_cell #(.BIT(QW - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .cell_i(chain[g]), .cell_o(chain[g+1])
		);
	end

	cau_post u_post (
		.clk(clk), .arst_n(arst_n), .en(en), .cell_i(chain[QW]),
		.out_valid(out_valid), .r_re(r_re), .r_im(r_im),
		.overflow(overflow), .div_zero(div_zero)
	);
endmodule

// ===== hw/rtl/cau_prep.sv =====
// Front end: products, sums, saturation of direct ops, divider and root setup.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_prep #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  logic [3:0] opcode,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	output cau_pkg::cell_t cell_o
);
	import cau_pkg::*;

	logic vld_s1;
	logic [3:0] op_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [2*DW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, paa_s1, pbb_s1, drr_s1, dii_s1;

	logic signed [WW-1:0] ar_w, ai_w, br_w, bi_w, n_re, n_im, v_re, v_im;
	logic [WW-1:0] dv, abs_re, abs_im;
	logic [DW:0] s_re, s_im;
	logic [RW-1:0] m_re, m_im, dvs_top;
	cell_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cell_o <= '0;
		end else if (en) begin
			vld_s1 <= vld;
			cell_o <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode;
			ar_s1 <= a_re;
			ai_s1 <= a_im;
			br_s1 <= b_re;
			bi_s1 <= b_im;
			prr_s1 <= a_re * b_re;
			pii_s1 <= a_im * b_im;
			pri_s1 <= a_re * b_im;
			pir_s1 <= a_im * b_re;
			paa_s1 <= a_re * a_re;
			pbb_s1 <= a_im * a_im;
			drr_s1 <= b_re * b_re;
			dii_s1 <= b_im * b_im;
		end
	end

	always_comb begin
		ar_w = WW'(ar_s1);
		ai_w = WW'(ai_s1);
		br_w = WW'(br_s1);
		bi_w = WW'(bi_s1);
		v_re = '0;
		v_im = '0;
		case (op_t'(op_s1))
			OP_ADD: begin v_re = ar_w + br_w; v_im = ai_w + bi_w; end
			OP_SUB: begin v_re = ar_w - br_w; v_im = ai_w - bi_w; end
			OP_MUL: begin
				v_re = (WW'(prr_s1) - WW'(pii_s1)) >>> FRAC_BITS;
				v_im = (WW'(pri_s1) + WW'(pir_s1)) >>> FRAC_BITS;
			end
			OP_NEG: begin v_re = -ar_w; v_im = -ai_w; end
			OP_CONJ: begin v_re = ar_w; v_im = -ai_w; end
			OP_NEGREAL: begin v_re = -ar_w; v_im = ai_w; end
			OP_SCALE: begin
				v_re = WW'(prr_s1) >>> FRAC_BITS;
				v_im = WW'(pir_s1) >>> FRAC_BITS;
			end
			OP_RE: v_re = ar_w;
			OP_IM: v_im = ai_w;
			default: ;
		endcase
		s_re = sat16(v_re);
		s_im = sat16(v_im);

		if (op_t'(op_s1) == OP_DIVREAL) begin
			n_re = ar_w;
			n_im = ai_w;
			dv = br_s1[DW-1] ? WW'(-br_w) : WW'(br_w);
		end else begin
			n_re = WW'(prr_s1) + WW'(pii_s1);
			n_im = WW'(pir_s1) - WW'(pri_s1);
			dv = WW'(drr_s1) + WW'(dii_s1);
		end
		abs_re = n_re[WW-1] ? WW'(-n_re) : WW'(n_re);
		abs_im = n_im[WW-1] ? WW'(-n_im) : WW'(n_im);
		m_re = RW'(abs_re) << FRAC_BITS;
		m_im = RW'(abs_im) << FRAC_BITS;
		dvs_top = RW'(dv) << QW;

		nxt = '0;
		nxt.vld = vld_s1;
		nxt.op = op_s1;
		nxt.fix_re = s_re[DW-1:0];
		nxt.fix_im = s_im[DW-1:0];
		nxt.fix_ovf = s_re[DW] | s_im[DW];
		nxt.dz = (dv == '0);
		nxt.dvs = RW'(dv);
		if (op_t'(op_s1) == OP_MAG) begin
			nxt.sq = 1'b1;
			nxt.rem_re = RW'(WW'(paa_s1) + WW'(pbb_s1));
		end else begin
			nxt.rem_re = m_re;
			nxt.rem_im = m_im;
			nxt.big_re = (m_re >= dvs_top);
			nxt.big_im = (m_im >= dvs_top);
			nxt.neg_re = n_re[WW-1] ^ ((op_t'(op_s1) == OP_DIVREAL) & br_s1[DW-1]);
			nxt.neg_im = n_im[WW-1] ^ ((op_t'(op_s1) == OP_DIVREAL) & br_s1[DW-1]);
		end
	end
endmodule

// ===== hw/rtl/cau_cell.sv =====
// One quotient / root bit cell of the divider and square-root row.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_cell #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cau_pkg::cell_t cell_i,
	output cau_pkg::cell_t cell_o
);
	import cau_pkg::*;

	logic [RW-1:0] sub_re, sub_im;
	cell_t nxt;

	always_comb begin
		sub_re = cell_i.sq ? ((RW'(cell_i.q_re) << (BIT + 1)) | (RW'(1) << (2 * BIT)))
			: (cell_i.dvs << BIT);
		sub_im = cell_i.dvs << BIT;
		nxt = cell_i;
		if (cell_i.rem_re >= sub_re) begin
			nxt.rem_re = cell_i.rem_re - sub_re;
			nxt.q_re[BIT] = 1'b1;
		end
		if (cell_i.rem_im >= sub_im) begin
			nxt.rem_im = cell_i.rem_im - sub_im;
			nxt.q_im[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_o <= '0;
		end else if (en) begin
			cell_o <= nxt;
		end
	end
endmodule

// ===== hw/rtl/cau_post.sv =====
// Back end: sign, saturation and result select into the output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_post (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cau_pkg::cell_t cell_i,
	output logic out_valid,
	output logic signed [15:0] r_re,
	output logic signed [15:0] r_im,
	output logic overflow,
	output logic div_zero
);
	import cau_pkg::*;

	logic signed [QW:0] sq_re, sq_im;
	logic [DW:0] s_re, s_im;
	logic signed [DW-1:0] n_re, n_im;
	logic n_ovf, n_dz;

	always_comb begin
		sq_re = cell_i.neg_re ? -$signed({1'b0, cell_i.q_re}) : $signed({1'b0, cell_i.q_re});
		sq_im = cell_i.neg_im ? -$signed({1'b0, cell_i.q_im}) : $signed({1'b0, cell_i.q_im});
		s_re = sat16(WW'(sq_re));
		s_im = sat16(WW'(sq_im));
		if (cell_i.big_re) s_re = cell_i.neg_re ? {1'b1, 16'sh8000} : {1'b1, 16'sh7fff};
		if (cell_i.big_im) s_im = cell_i.neg_im ? {1'b1, 16'sh8000} : {1'b1, 16'sh7fff};
		n_re = cell_i.fix_re;
		n_im = cell_i.fix_im;
		n_ovf = cell_i.fix_ovf;
		n_dz = 1'b0;
		case (op_t'(cell_i.op)) inside
			OP_DIV, OP_DIVREAL: begin
				if (cell_i.dz) begin
					n_re = '0;
					n_im = '0;
					n_ovf = 1'b0;
					n_dz = 1'b1;
				end else begin
					n_re = s_re[DW-1:0];
					n_im = s_im[DW-1:0];
					n_ovf = s_re[DW] | s_im[DW];
				end
			end
			OP_MAG: begin
				s_re = sat16(WW'(cell_i.q_re));
				n_re = s_re[DW-1:0];
				n_im = '0;
				n_ovf = s_re[DW];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= cell_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_re <= n_re;
			r_im <= n_im;
			overflow <= n_ovf;
			div_zero <= n_dz;
		end
	end
endmodule

// ===== hw/rtl/cau_chk.sv =====
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on complex_arith_unit_macros.svh.
`timescale 1ns / 1ps
`include "complex_arith_unit_macros.svh"
module cau_chk (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] r_re,
	input logic signed [15:0] r_im,
	input logic overflow,
	input logic div_zero
);
	`CAU_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid, "result word dropped")
	`CAU_ASSERT_IMP(a_stall, 1'b1, in_stall == (out_valid && out_stall), "stall mismatch")
	`CAU_ASSERT_IMP(a_dz, out_valid && div_zero, r_re == 16'sd0 && r_im == 16'sd0, "dz nonzero")
	`CAU_ASSERT_IMP(a_flags, out_valid && div_zero, !overflow, "dz with overflow")
endmodule

bind complex_arith_unit cau_chk u_cau_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .r_re(r_re), .r_im(r_im), .overflow(overflow),
	.div_zero(div_zero)
);
